[hdl/erm_pkg.sv]
// ---------------------------------------------------------------------------
// erm_pkg: shared types and constants
// Word layouts and polynomial constants for the Euler XYZ rotation block.
// ---------------------------------------------------------------------------
package erm_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int COEF_WIDTH  = 16;

  // Taylor constants of sin(u*pi/2), Q30
  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598669;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026996;
  localparam logic [30:0] C9 = 31'd172273;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle_about_x;
    logic signed [ANGLE_WIDTH-1:0] angle_about_y;
    logic signed [ANGLE_WIDTH-1:0] angle_about_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_r0c0;
    logic signed [COEF_WIDTH-1:0] coef_r0c1;
    logic signed [COEF_WIDTH-1:0] coef_r0c2;
    logic signed [COEF_WIDTH-1:0] coef_r1c0;
    logic signed [COEF_WIDTH-1:0] coef_r1c1;
    logic signed [COEF_WIDTH-1:0] coef_r1c2;
    logic signed [COEF_WIDTH-1:0] coef_r2c0;
    logic signed [COEF_WIDTH-1:0] coef_r2c1;
    logic signed [COEF_WIDTH-1:0] coef_r2c2;
  } out_word_t;

endpackage

[hdl/erm_lane.sv]
// ---------------------------------------------------------------------------
// erm_lane: pipelined sine lane
// Eight-stage Horner evaluation of the quarter-wave sine, at most one multiply a stage.
// ---------------------------------------------------------------------------
module erm_lane #(
  parameter int AW = erm_pkg::ANGLE_WIDTH,
  parameter int CW = erm_pkg::COEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        angle,
  output logic signed [CW-1:0] sine
);
  localparam int QW = AW - 2;
  localparam int F  = CW - 2;

  logic [30:0] u0_r, u1_r, u2_r, u3_r, u4_r, u5_r;
  logic        n0_r, n1_r, n2_r, n3_r, n4_r, n5_r, n6_r;
  logic [30:0] sq1_r, sq2_r, sq3_r, sq4_r;
  logic [30:0] t2_r, t3_r, t4_r, t5_r;
  logic [31:0] s6_r;
  logic signed [CW-1:0] sine_r;

  logic [29:0] phase;
  logic [30:0] u_nxt;
  logic [61:0] p1, p2, p3, p4, p5, p6;
  logic [32:0] s_rnd;
  logic [F:0]  mag;

  always_comb begin
    phase = {angle[QW-1:0], (30-QW)'(0)};
    u_nxt = angle[QW] ? (erm_pkg::ONE_Q30 - {1'b0, phase}) : {1'b0, phase};
    p1 = u0_r * u0_r;
    p2 = sq1_r * erm_pkg::C9;
    p3 = sq2_r * t2_r;
    p4 = sq3_r * t3_r;
    p5 = sq4_r * t4_r;
    p6 = u5_r * t5_r;
    s_rnd = {1'b0, s6_r} + 33'(33'd1 << (29 - F));
    // cap the magnitude at 1.0
    if (s_rnd[32:30-F] > 33'(33'd1 << F)) begin
      mag = (F+1)'(1) << F;
    end else begin
      mag = s_rnd[30:30-F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0_r  <= u_nxt;                 n0_r <= angle[AW-1];
      sq1_r <= p1[60:30]; u1_r <= u0_r; n1_r <= n0_r;
      t2_r  <= 31'({1'b0, erm_pkg::C7} - p2[61:30]);
      sq2_r <= sq1_r; u2_r <= u1_r; n2_r <= n1_r;
      t3_r  <= 31'({1'b0, erm_pkg::C5} - p3[61:30]);
      sq3_r <= sq2_r; u3_r <= u2_r; n3_r <= n2_r;
      t4_r  <= 31'({1'b0, erm_pkg::C3} - p4[61:30]);
      sq4_r <= sq3_r; u4_r <= u3_r; n4_r <= n3_r;
      t5_r  <= 31'({1'b0, erm_pkg::C1} - p5[61:30]);
      u5_r  <= u4_r; n5_r <= n4_r;
      s6_r  <= p6[61:30]; n6_r <= n5_r;
      sine_r <= n6_r ? -$signed(CW'(mag)) : $signed(CW'(mag));
    end
  end

  assign sine = sine_r;
endmodule

[hdl/erm_merge.sv]
// ---------------------------------------------------------------------------
// erm_merge: matrix product stage
// Forms Rx*Ry, then (Rx*Ry)*Rz, each product entry rounded half up and saturated.
// ---------------------------------------------------------------------------
module erm_merge #(
  parameter int CW = erm_pkg::COEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] sx, cx, sy, cy, sz, cz,
  output erm_pkg::out_word_t   res
);
  localparam int F  = CW - 2;
  localparam int PW = 2 * CW + 2;
  localparam logic signed [PW-1:0] ONE  = PW'(1) <<< F;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

  function automatic logic signed [CW-1:0] rnd(input logic signed [PW-1:0] acc);
    logic signed [PW-1:0] v;
    v = (acc + HALF) >>> F;
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return v[CW-1:0];
  endfunction

  // stage 1: Rx*Ry products
  logic signed [2*CW-1:0] sxsy_r, sxcy_r, cxsy_r, cxcy_r;
  logic signed [CW-1:0] sx1_r, cx1_r, sy1_r, cy1_r, sz1_r, cz1_r;
  // stage 2: rounded Rx*Ry
  logic signed [CW-1:0] a2_r, b2_r, r12_2_r, r22_2_r;
  logic signed [CW-1:0] sx2_r, cx2_r, sy2_r, cy2_r, sz2_r, cz2_r;
  // stage 3: products with Rz
  logic signed [2*CW-1:0] q00_r, q01_r, q10a_r, q10b_r, q11a_r, q11b_r;
  logic signed [2*CW-1:0] q20a_r, q20b_r, q21a_r, q21b_r;
  logic signed [CW-1:0] sy3_r, r12_3_r, r22_3_r;
  erm_pkg::out_word_t res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_r <= sx * sy; sxcy_r <= sx * cy; cxsy_r <= cx * sy; cxcy_r <= cx * cy;
      sx1_r <= sx; cx1_r <= cx; sy1_r <= sy; cy1_r <= cy; sz1_r <= sz; cz1_r <= cz;

      a2_r    <= rnd(PW'(sxsy_r));
      b2_r    <= rnd(-PW'(cxsy_r));
      r12_2_r <= rnd(-PW'(sxcy_r));
      r22_2_r <= rnd(PW'(cxcy_r));
      sx2_r <= sx1_r; cx2_r <= cx1_r; sy2_r <= sy1_r; cy2_r <= cy1_r;
      sz2_r <= sz1_r; cz2_r <= cz1_r;

      q00_r  <= cy2_r * cz2_r;  q01_r  <= cy2_r * sz2_r;
      q10a_r <= a2_r * cz2_r;   q10b_r <= cx2_r * sz2_r;
      q11a_r <= a2_r * sz2_r;   q11b_r <= cx2_r * cz2_r;
      q20a_r <= b2_r * cz2_r;   q20b_r <= sx2_r * sz2_r;
      q21a_r <= b2_r * sz2_r;   q21b_r <= sx2_r * cz2_r;
      sy3_r <= sy2_r; r12_3_r <= r12_2_r; r22_3_r <= r22_2_r;

      res_r.coef_r0c0 <= rnd(PW'(q00_r));
      res_r.coef_r0c1 <= rnd(-PW'(q01_r));
      res_r.coef_r0c2 <= sy3_r;
      res_r.coef_r1c0 <= rnd(PW'(q10a_r) + PW'(q10b_r));
      res_r.coef_r1c1 <= rnd(PW'(q11b_r) - PW'(q11a_r));
      res_r.coef_r1c2 <= r12_3_r;
      res_r.coef_r2c0 <= rnd(PW'(q20a_r) + PW'(q20b_r));
      res_r.coef_r2c1 <= rnd(PW'(q21b_r) - PW'(q21a_r));
      res_r.coef_r2c2 <= r22_3_r;
    end
  end

  assign res = res_r;
endmodule

[hdl/euler_xyz_rotation_matrix_core.sv]
// Throughput: one word per cycle; the whole pipeline holds while out_stall
//   keeps a finished word waiting (the output stage is the last pipe register).
// Reset: rst_n (synchronous, active low) clears the valid pipe only; data
//   registers are not reset. No state is kept between words.
// ---------------------------------------------------------------------------
// euler_xyz_rotation_matrix_core: Euler XYZ rotation matrix
// Six sine lanes (sin/cos of X, Y, Z) feed a merge stage forming Rx*Ry*Rz.
// ---------------------------------------------------------------------------
module euler_xyz_rotation_matrix_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  erm_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output erm_pkg::out_word_t out_word
);
  localparam int AW  = erm_pkg::ANGLE_WIDTH;
  localparam int CW  = erm_pkg::COEF_WIDTH;
  localparam int LAT = 12;  // 8 lane stages + 4 merge stages
  localparam logic [AW-1:0] QUARTER = AW'(1) << (AW - 2);

  logic [LAT-1:0] vld_r, vld_nxt;
  logic en;
  logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
  logic [AW-1:0] ax, ay, az;

  // Pipe advances unless a finished word is held at the output.
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign ax = in_word.angle_about_x;
  assign ay = in_word.angle_about_y;
  assign az = in_word.angle_about_z;

  // cosine lanes see the angle advanced by a quarter turn
  erm_lane #(.AW(AW), .CW(CW)) u_lane_sx (.clk, .en, .angle(ax), .sine(sx));
  erm_lane #(.AW(AW), .CW(CW)) u_lane_cx (.clk, .en, .angle(ax + QUARTER), .sine(cx));
  erm_lane #(.AW(AW), .CW(CW)) u_lane_sy (.clk, .en, .angle(ay), .sine(sy));
  erm_lane #(.AW(AW), .CW(CW)) u_lane_cy (.clk, .en, .angle(ay + QUARTER), .sine(cy));
  erm_lane #(.AW(AW), .CW(CW)) u_lane_sz (.clk, .en, .angle(az), .sine(sz));
  erm_lane #(.AW(AW), .CW(CW)) u_lane_cz (.clk, .en, .angle(az + QUARTER), .sine(cz));

  erm_merge #(.CW(CW)) u_merge (
    .clk, .en, .sx, .cx, .sy, .cy, .sz, .cz, .res(out_word)
  );

  assign out_valid = vld_r[LAT-1];

`ifndef SYNTH
  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  // saturation keeps coefficients r1c0 and r2c1 within +/-1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.coef_r1c0 <= $signed(CW'(1) << (CW - 2)) &&
                   out_word.coef_r1c0 >= -$signed(CW'(1) << (CW - 2)) &&
                   out_word.coef_r2c1 <= $signed(CW'(1) << (CW - 2)) &&
                   out_word.coef_r2c1 >= -$signed(CW'(1) << (CW - 2))))
    else $error("coefficient out of range");
  // a held output stalls the input side
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipe moved while output held");
`endif

endmodule
